FILE: sv/integer_calculator_alu_assert.svh
// assertion macros for the integer calculator
`ifndef INTEGER_CALCULATOR_ALU_ASSERT_SVH
`define INTEGER_CALCULATOR_ALU_ASSERT_SVH

`ifndef NO_ASSERTIONS
// property checked outside of reset
`define ICA_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// property checked in and out of reset
`define ICA_CHECK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define ICA_CHECK(label, prop, msg)
`define ICA_CHECK_ALWAYS(label, prop, msg)
`endif

`endif

FILE: sv/ica_pkg.sv
package ica_pkg;

   // payload field widths
   localparam int CMD_W   = 3;
   localparam int OPND_W  = 32;
   localparam int WHOLE_W = 64;
   localparam int FRAC_W  = 16;
   localparam int ST_W    = 3;

   // parameter defaults and ranges
   localparam int OPERAND_WIDTH_DEF = 32;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int OPW_MAX = 32;
   localparam int FRB_MAX = 31;

   // power cells
   localparam int BASE_W   = OPW_MAX - 1;
   localparam int ACC_W    = 63;
   localparam int LEFT_W   = 6;
   localparam int PW_STEPS = 63;

   // divide and square root cells
   localparam int DV_W   = (OPW_MAX > FRB_MAX + 1) ? OPW_MAX : FRB_MAX + 1;
   localparam int SQ_MAX = (OPW_MAX + 2 * FRB_MAX) / 2;
   localparam int RAD_W  = 2 * SQ_MAX;
   localparam int SR_W   = SQ_MAX + 2;

   localparam logic [WHOLE_W-1:0] WHOLE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

   // commands
   localparam logic [CMD_W-1:0] CMD_ADD  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SUB  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_MUL  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DIV  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_POW  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_SQRT = 3'd5;

   // status codes
   localparam logic [ST_W-1:0] ST_OK   = 3'd0;
   localparam logic [ST_W-1:0] ST_DIV0 = 3'd1;
   localparam logic [ST_W-1:0] ST_NEG  = 3'd2;
   localparam logic [ST_W-1:0] ST_OVF  = 3'd3;
   localparam logic [ST_W-1:0] ST_BAD  = 3'd4;

   // request as it travels down the cell chain
   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [ST_W-1:0]    status;
      logic [WHOLE_W-1:0] whole;
      logic               pw_run;
      logic               pw_neg;
      logic [BASE_W-1:0]  pw_base;
      logic [ACC_W-1:0]   pw_acc;
      logic [LEFT_W-1:0]  pw_left;
      logic               dv_neg;
      logic [DV_W-1:0]    dv_num;
      logic [DV_W-1:0]    dv_den;
      logic [DV_W-1:0]    dv_rem;
      logic [RAD_W-1:0]   sq_rad;
      logic [SR_W-1:0]    sq_rem;
      logic [SQ_MAX-1:0]  sq_root;
   } item_type;

endpackage

FILE: sv/ica_if.sv
interface ica_req_if;
   import ica_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic signed [OPND_W-1:0] operand_a;
   logic signed [OPND_W-1:0] operand_b;
   modport source (output valid, command, operand_a, operand_b, input ready);
   modport sink (input valid, command, operand_a, operand_b, output ready);
endinterface

interface ica_rsp_if;
   import ica_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [WHOLE_W-1:0] result_whole;
   logic [FRAC_W-1:0]         result_fraction;
   logic [ST_W-1:0]           status;
   modport source (output valid, result_whole, result_fraction, status, input ready);
   modport sink (input valid, result_whole, result_fraction, status, output ready);
endinterface

FILE: sv/ica_pow_cell.sv
module ica_pow_cell #(
   parameter int FRACTION_BITS = ica_pkg::FRACTION_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              v_i,
   input  ica_pkg::item_type item_i,
   output logic              v_o,
   output ica_pkg::item_type item_o
);
   import ica_pkg::*;

   logic [ACC_W-1:0]              one_c;
   logic [32+BASE_W-1:0]          p_lo;
   logic [ACC_W-32+BASE_W-1:0]    p_hi;
   logic [ACC_W+BASE_W-1:0]       prod;
   logic                          big;
   item_type                      item_in;
   item_type                      item_ff;
   logic                          v_ff;

   assign one_c = ACC_W'(1) << FRACTION_BITS;

   // accumulator times base, split in two partial products
   assign p_lo = item_i.pw_acc[31:0] * item_i.pw_base;
   assign p_hi = item_i.pw_acc[ACC_W-1:32] * item_i.pw_base;
   assign prod = {p_hi, 32'b0} + (ACC_W+BASE_W)'(p_lo);
   assign big  = |prod[ACC_W+BASE_W-1:ACC_W];

   // one exponent step
   always_comb begin
      item_in = item_i;
      if (item_i.pw_run && item_i.pw_left != '0) begin
         if (item_i.pw_neg) begin
            // divisor grows until it passes one, then clamps just above it
            if (item_i.pw_acc <= one_c) begin
               item_in.pw_acc  = (big || prod[ACC_W-1:0] > one_c) ?
                                 one_c + ACC_W'(1) : prod[ACC_W-1:0];
               item_in.pw_left = item_i.pw_left - LEFT_W'(1);
               item_in.dv_den  = item_in.pw_acc[DV_W-1:0];
            end
         end else if (item_i.status == ST_OK) begin
            if (big) begin
               item_in.status = ST_OVF;
            end else begin
               item_in.pw_acc  = prod[ACC_W-1:0];
               item_in.pw_left = item_i.pw_left - LEFT_W'(1);
            end
         end
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (adv) begin
         v_ff <= v_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff <= item_in;
      end
   end

   assign v_o    = v_ff;
   assign item_o = item_ff;

endmodule

FILE: sv/ica_dvsq_cell.sv
module ica_dvsq_cell #(
   parameter bit DO_DIV  = 1'b1,
   parameter bit DO_SQRT = 1'b1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              v_i,
   input  ica_pkg::item_type item_i,
   output logic              v_o,
   output ica_pkg::item_type item_o
);
   import ica_pkg::*;

   logic [DV_W:0]  dt;
   logic [DV_W:0]  dd;
   logic           dq;
   logic [SR_W-1:0] st;
   logic [SR_W-1:0] trial;
   logic           sq;
   item_type       item_in;
   item_type       item_ff;
   logic           v_ff;

   // restoring division: bring down one dividend bit
   assign dt = {item_i.dv_rem, item_i.dv_num[DV_W-1]};
   assign dd = {1'b0, item_i.dv_den};
   assign dq = (dt >= dd);

   // restoring square root: bring down two radicand bits
   assign st    = {item_i.sq_rem[SR_W-3:0], item_i.sq_rad[RAD_W-1 -: 2]};
   assign trial = {item_i.sq_root, 2'b01};
   assign sq    = (st >= trial);

   always_comb begin
      item_in = item_i;
      if (DO_DIV) begin
         item_in.dv_rem = dq ? DV_W'(dt - dd) : dt[DV_W-1:0];
         item_in.dv_num = {item_i.dv_num[DV_W-2:0], dq};
      end
      if (DO_SQRT) begin
         item_in.sq_rem  = sq ? st - trial : st;
         item_in.sq_root = {item_i.sq_root[SQ_MAX-2:0], sq};
         item_in.sq_rad  = {item_i.sq_rad[RAD_W-3:0], 2'b00};
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (adv) begin
         v_ff <= v_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff <= item_in;
      end
   end

   assign v_o    = v_ff;
   assign item_o = item_ff;

endmodule

FILE: sv/integer_calculator_alu.sv
// Integer calculator: add, subtract, multiply, divide, power and square root on two
// signed operands, one request per clock cycle sustained. Every request walks the
// same chain: a decode stage, 63 power cells (one multiply by the base each), then
// max(OPERAND_WIDTH, FRACTION_BITS+1, (OPERAND_WIDTH+2*FRACTION_BITS)/2) cells that
// each produce one quotient bit, one root bit or both, then the output register. The
// chain stops only while its last stage holds a result and the output register is
// still full.
`include "integer_calculator_alu_assert.svh"
module integer_calculator_alu #(
   parameter int OPERAND_WIDTH = ica_pkg::OPERAND_WIDTH_DEF,
   parameter int FRACTION_BITS = ica_pkg::FRACTION_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   ica_req_if.sink   req_bus,
   ica_rsp_if.source rsp_bus
);
   import ica_pkg::*;

   localparam int DIV_STEPS = (OPERAND_WIDTH > FRACTION_BITS + 1) ?
                              OPERAND_WIDTH : FRACTION_BITS + 1;
   localparam int SQ_STEPS  = (OPERAND_WIDTH + 2 * FRACTION_BITS) / 2;
   localparam int DS_CELLS  = (DIV_STEPS > SQ_STEPS) ? DIV_STEPS : SQ_STEPS;
   localparam int NSTG      = 1 + PW_STEPS + DS_CELLS;
   localparam int DV_SHIFT  = DV_W - DIV_STEPS;
   localparam int SQ_SHIFT  = 2 * FRACTION_BITS + RAD_W - 2 * SQ_STEPS;

   logic                     adv;
   logic [WHOLE_W-1:0]       a64;
   logic [WHOLE_W-1:0]       b64;
   logic [WHOLE_W-1:0]       mag_a;
   logic [WHOLE_W-1:0]       mag_b;
   logic [WHOLE_W-1:0]       neg_b;
   logic signed [OPND_W-1:0] mul_a;
   logic signed [OPND_W-1:0] mul_b;
   logic signed [WHOLE_W-1:0] mul_p;
   logic                     a_neg;
   logic                     b_neg;
   item_type                 front_in;
   item_type                 front_item_ff;
   logic                     front_v_ff;
   item_type                 stg_item [NSTG];
   logic                     stg_v [NSTG];
   item_type                 last;
   logic                     last_v;
   logic [WHOLE_W-1:0]       q64;
   logic [SQ_MAX-1:0]        sq_mask;
   logic [WHOLE_W-1:0]       pack_whole;
   logic [FRAC_W-1:0]        pack_frac;
   logic                     out_v_ff;
   logic                     out_v_in;
   logic [WHOLE_W-1:0]       out_whole_ff;
   logic [FRAC_W-1:0]        out_frac_ff;
   logic [ST_W-1:0]          out_status_ff;

   // the chain moves unless its last result is blocked by a full output register
   assign last   = stg_item[NSTG-1];
   assign last_v = stg_v[NSTG-1];
   assign adv    = !last_v || !out_v_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   // operands sign extended from the configured width
   assign a64   = 64'($signed(req_bus.operand_a[OPERAND_WIDTH-1:0]));
   assign b64   = 64'($signed(req_bus.operand_b[OPERAND_WIDTH-1:0]));
   assign a_neg = a64[WHOLE_W-1];
   assign b_neg = b64[WHOLE_W-1];
   assign mag_a = a_neg ? -a64 : a64;
   assign neg_b = -b64;
   assign mag_b = b_neg ? neg_b : b64;
   assign mul_a = a64[OPND_W-1:0];
   assign mul_b = b64[OPND_W-1:0];
   assign mul_p = mul_a * mul_b;

   // request decode
   always_comb begin
      front_in         = '0;
      front_in.cmd     = req_bus.command;
      front_in.status  = ST_OK;
      front_in.pw_acc  = ACC_W'(1);
      front_in.pw_base = mag_a[BASE_W-1:0];
      unique case (req_bus.command)
         CMD_ADD: begin
            front_in.whole = a64 + b64;
         end
         CMD_SUB: begin
            front_in.whole = a64 - b64;
         end
         CMD_MUL: begin
            front_in.whole = mul_p;
         end
         CMD_DIV: begin
            if (b64 == '0) begin
               front_in.status = ST_DIV0;
            end
            front_in.dv_neg = a_neg ^ b_neg;
            front_in.dv_num = mag_a[DV_W-1:0] << DV_SHIFT;
            front_in.dv_den = mag_b[DV_W-1:0];
         end
         CMD_POW: begin
            if (a_neg) begin
               front_in.status = ST_NEG;
            end else if (b64 == '0 || a64 == 64'd1) begin
               front_in.whole = 64'd1;
            end else if (a64 == '0) begin
               if (b_neg) begin
                  front_in.status = ST_OVF;
               end
            end else if (!b_neg) begin
               // any base of two or more overflows past exponent 63
               if (|b64[WHOLE_W-2:LEFT_W]) begin
                  front_in.status = ST_OVF;
               end else begin
                  front_in.pw_run  = 1'b1;
                  front_in.pw_left = b64[LEFT_W-1:0];
               end
            end else begin
               front_in.pw_run  = 1'b1;
               front_in.pw_neg  = 1'b1;
               front_in.pw_left = (|neg_b[WHOLE_W-1:LEFT_W]) ?
                                  LEFT_W'(PW_STEPS) : neg_b[LEFT_W-1:0];
               front_in.dv_num  = DV_W'(1) << (FRACTION_BITS + DV_SHIFT);
            end
         end
         CMD_SQRT: begin
            if (a_neg) begin
               front_in.status = ST_NEG;
            end
            front_in.sq_rad = RAD_W'(mag_a[BASE_W-1:0]) << SQ_SHIFT;
         end
         default: begin
            front_in.status = ST_BAD;
         end
      endcase
   end

   // decode stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         front_v_ff <= 1'b0;
      end else if (adv) begin
         front_v_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         front_item_ff <= front_in;
      end
   end

   assign stg_item[0] = front_item_ff;
   assign stg_v[0]    = front_v_ff;

   // power cells
   for (genvar i = 0; i < PW_STEPS; i++) begin : g_pow
      ica_pow_cell #(
         .FRACTION_BITS (FRACTION_BITS)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .v_i    (stg_v[i]),
         .item_i (stg_item[i]),
         .v_o    (stg_v[i+1]),
         .item_o (stg_item[i+1])
      );
   end

   // quotient and root cells
   for (genvar j = 0; j < DS_CELLS; j++) begin : g_dvsq
      ica_dvsq_cell #(
         .DO_DIV  (j < DIV_STEPS),
         .DO_SQRT (j < SQ_STEPS)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .v_i    (stg_v[PW_STEPS+j]),
         .item_i (stg_item[PW_STEPS+j]),
         .v_o    (stg_v[1+PW_STEPS+j]),
         .item_o (stg_item[1+PW_STEPS+j])
      );
   end

   // result assembly
   assign q64     = WHOLE_W'(last.dv_num);
   assign sq_mask = (SQ_MAX'(1) << FRACTION_BITS) - SQ_MAX'(1);

   always_comb begin
      pack_whole = '0;
      pack_frac  = '0;
      if (last.status == ST_OVF) begin
         pack_whole = WHOLE_MAX;
         pack_frac  = '1;
      end else if (last.status == ST_OK) begin
         case (last.cmd) inside
            CMD_ADD, CMD_SUB, CMD_MUL: begin
               pack_whole = last.whole;
            end
            CMD_DIV: begin
               pack_whole = last.dv_neg ? -q64 : q64;
            end
            CMD_POW: begin
               if (last.pw_run && last.pw_neg) begin
                  pack_frac = last.dv_num[FRAC_W-1:0];
               end else if (last.pw_run) begin
                  pack_whole = WHOLE_W'(last.pw_acc);
               end else begin
                  pack_whole = last.whole;
               end
            end
            CMD_SQRT: begin
               pack_whole = WHOLE_W'(last.sq_root >> FRACTION_BITS);
               pack_frac  = FRAC_W'(last.sq_root & sq_mask);
            end
            default: begin
               pack_whole = '0;
            end
         endcase
      end
   end

   // output register
   assign out_v_in = (adv && last_v) || (out_v_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && last_v) begin
         out_whole_ff  <= pack_whole;
         out_frac_ff   <= pack_frac;
         out_status_ff <= last.status;
      end
   end

   assign rsp_bus.valid           = out_v_ff;
   assign rsp_bus.result_whole    = out_whole_ff;
   assign rsp_bus.result_fraction = out_frac_ff;
   assign rsp_bus.status          = out_status_ff;

   // checks
   `ICA_CHECK(a_req_enters, (req_bus.valid && req_bus.ready) |=> front_v_ff, "accepted request missing from decode stage")
   `ICA_CHECK(a_last_held, (last_v && out_v_ff && !rsp_bus.ready) |=> last_v, "blocked result dropped from the chain")
   `ICA_CHECK(a_err_zero, (out_v_ff && out_status_ff != ST_OK && out_status_ff != ST_OVF) |-> (out_whole_ff == '0 && out_frac_ff == '0), "error result carries a value")
   `ICA_CHECK_ALWAYS(a_reset_clear, reset |=> (!out_v_ff && !front_v_ff), "valid set after reset")

endmodule

FILE: sim/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ica_pkg::*;

   typedef struct {
      logic signed [WHOLE_W-1:0] whole;
      logic [FRAC_W-1:0]         fraction;
      logic [ST_W-1:0]           status;
   } calc_result_t;

   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 130;

   // command codes with no operation behind them
   localparam logic [CMD_W-1:0] CMD_INVALID_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_INVALID_HI = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ica_req_if req_bus();
   ica_rsp_if rsp_bus();

   calc_result_t expected_results[$];
   int  mismatch_count = 0;
   bit  idle_enable = 1'b1;
   int  hold_asks = 0;
   int  hold_served = 0;
   int  hold_left = 0;
   int  quiet_cycles = 0;

   integer_calculator_alu u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   // expected result of one request
   function automatic calc_result_t compute_result(logic [CMD_W-1:0] cmd,
                                                   logic signed [OPND_W-1:0] a,
                                                   logic signed [OPND_W-1:0] b);
      calc_result_t res;
      logic signed [63:0] sa;
      logic signed [63:0] sb;
      logic [127:0] prod;
      logic [63:0] acc;
      logic [63:0] divisor;
      logic [63:0] rad;
      logic [63:0] root;
      logic [63:0] cand;
      logic [63:0] left;
      bit ovf;
      sa = a;
      sb = b;
      res.whole = '0;
      res.fraction = '0;
      res.status = ST_OK;
      case (cmd)
         CMD_ADD: res.whole = sa + sb;
         CMD_SUB: res.whole = sa - sb;
         CMD_MUL: res.whole = sa * sb;
         CMD_DIV: begin
            if (sb == 0) res.status = ST_DIV0;
            else res.whole = sa / sb;
         end
         CMD_POW: begin
            if (sa < 0) begin
               res.status = ST_NEG;
            end else if (sb == 0 || sa == 1) begin
               res.whole = 64'sd1;
            end else if (sa == 0) begin
               if (sb < 0) begin
                  res.status = ST_OVF;
                  res.whole = WHOLE_MAX;
                  res.fraction = '1;
               end
            end else if (sb > 0) begin
               acc = 64'd1;
               ovf = (sb >= 64);
               for (longint n = 0; !ovf && n < sb; n++) begin
                  prod = {64'd0, acc} * {64'd0, sa};
                  if (prod > {64'd0, WHOLE_MAX}) ovf = 1'b1;
                  else acc = prod[63:0];
               end
               if (ovf) begin
                  res.status = ST_OVF;
                  res.whole = WHOLE_MAX;
                  res.fraction = '1;
               end else begin
                  res.whole = acc;
               end
            end else begin
               // negative exponent: fraction of one over base^-exponent
               divisor = 64'd1;
               left = -sb;
               while (left > 0 && divisor <= 64'd65536) begin
                  divisor = divisor * sa;
                  left--;
               end
               acc = 64'd65536 / divisor;
               res.fraction = acc[15:0];
            end
         end
         CMD_SQRT: begin
            if (sa < 0) begin
               res.status = ST_NEG;
            end else begin
               rad = sa << 32;
               root = '0;
               for (int bitpos = 47; bitpos >= 0; bitpos--) begin
                  cand = root | (64'd1 << bitpos);
                  prod = {64'd0, cand} * {64'd0, cand};
                  if (prod <= {64'd0, rad}) root = cand;
               end
               res.whole = root >> 16;
               res.fraction = root[15:0];
            end
         end
         default: res.status = ST_BAD;
      endcase
      return res;
   endfunction

   // send one request, optionally idling first
   task automatic send_request(logic [CMD_W-1:0] cmd, logic [31:0] a, logic [31:0] b);
      while (idle_enable && $urandom_range(99) < 31) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.command   <= cmd;
      req_bus.operand_a <= a;
      req_bus.operand_b <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_results.push_back(compute_result(cmd, a, b));
   endtask

   // stop offering and wait until every result has come back
   task automatic wait_all_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(5))
         0: return $urandom;
         1: return $urandom_range(16) - 8;
         2: case ($urandom_range(4))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0;
               3: return 32'hFFFF_FFFF;
               default: return 32'h1;
            endcase
         3: return $urandom_range(65535);
         4: return -$urandom_range(65535);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      send_request(CMD_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_request(CMD_ADD, 32'h8000_0000, 32'h8000_0000);
      send_request(CMD_SUB, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(CMD_SUB, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(CMD_MUL, 32'h8000_0000, 32'h8000_0000);
      send_request(CMD_MUL, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(CMD_DIV, 32'd100, 32'd0);
      send_request(CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
      send_request(CMD_DIV, -32'sd7, 32'd2);
      send_request(CMD_SQRT, 32'hFFFF_FFFF, 32'd5);
      send_request(CMD_SQRT, 32'h7FFF_FFFF, 32'd0);
      send_request(CMD_SQRT, 32'd2, 32'hFFFF_FFFF);
      send_request(CMD_SQRT, 32'd0, 32'd0);
      send_request(CMD_POW, -32'sd2, 32'd3);
      send_request(CMD_POW, -32'sd2, 32'd0);
      send_request(CMD_POW, 32'd0, 32'd0);
      send_request(CMD_POW, 32'd0, -32'sd1);
      send_request(CMD_POW, 32'd0, 32'd5);
      send_request(CMD_POW, 32'd2, 32'd62);
      send_request(CMD_POW, 32'd2, 32'd63);
      send_request(CMD_POW, 32'd3, -32'sd2);
      send_request(CMD_POW, 32'd2, 32'h8000_0000);
      send_request(CMD_POW, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_request(CMD_INVALID_LO, 32'd1, 32'd1);
      send_request(CMD_INVALID_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      wait_all_results();
   endtask

   task automatic test_random_mix(int count);
      logic [CMD_W-1:0] cmd;
      logic [31:0] a;
      logic [31:0] b;
      for (int i = 0; i < count; i++) begin
         cmd = CMD_W'($urandom_range(7));
         a = pick_operand();
         b = pick_operand();
         if (cmd == CMD_POW && $urandom_range(3) != 0) begin
            a = $urandom_range(3) == 0 ? pick_operand() : $urandom_range(20);
            b = $urandom_range(90) - 20;
         end
         if (cmd == CMD_SQRT && $urandom_range(3) != 0) a[31] = 1'b0;
         send_request(cmd, a, b);
      end
   endtask

   task automatic test_no_idle();
      idle_enable = 1'b0;
      test_random_mix(250);
      idle_enable = 1'b1;
      wait_all_results();
   endtask

   // receiver holds off while requests keep coming
   task automatic test_backpressure();
      hold_asks++;
      test_random_mix(200);
      wait_all_results();
   endtask

   // request side stimulus
   initial begin
      req_bus.valid     <= 1'b0;
      req_bus.command   <= '0;
      req_bus.operand_a <= '0;
      req_bus.operand_b <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_mix(500);
      test_no_idle();
      test_backpressure();
      test_random_mix(550);
      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   // result side ready with random stalls and requested hold-offs
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_asks != hold_served) begin
         hold_served <= hold_served + 1;
         hold_left <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= !idle_enable || $urandom_range(99) >= 31;
      end
   end

   // compare each result with the oldest expectation
   always @(posedge clock) begin
      calc_result_t exp_res;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result whole=%0d fraction=%0d status=%0d", $realtime,
                     rsp_bus.result_whole, rsp_bus.result_fraction, rsp_bus.status);
            mismatch_count++;
         end else begin
            exp_res = expected_results.pop_front();
            if (rsp_bus.result_whole !== exp_res.whole) begin
               $display("%0t: whole expected %0d actual %0d", $realtime,
                        exp_res.whole, rsp_bus.result_whole);
               mismatch_count++;
            end
            if (rsp_bus.result_fraction !== exp_res.fraction) begin
               $display("%0t: fraction expected %0d actual %0d", $realtime,
                        exp_res.fraction, rsp_bus.result_fraction);
               mismatch_count++;
            end
            if (rsp_bus.status !== exp_res.status) begin
               $display("%0t: status expected %0d actual %0d", $realtime,
                        exp_res.status, rsp_bus.status);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
